// File: rtl/cau_pkg.sv
package cau_pkg;

	// Field widths of one transaction
	localparam int OP_W  = 3;
	localparam int DW    = 32;
	localparam int PW    = 64;
	// Quotient and root bits, one per iteration stage
	localparam int STEPS = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_DIV   = 3'd3,
		OP_MAG   = 3'd4,
		OP_MAGSQ = 3'd5
	} op_t;

	// One restoring divider lane: partial remainder, and low dividend bits
	// that shift out while quotient bits shift in
	typedef struct packed {
		logic [PW-1:0] rem;
		logic [DW-1:0] lq;
		logic          neg;
		logic          povf;
	} lane_t;

	// Digit-by-digit square root state
	typedef struct packed {
		logic [PW-1:0]  v;
		logic [DW+1:0]  rem;
		logic [DW-1:0]  root;
	} root_t;

	// Everything that travels through the iteration stages
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            dz;
		logic [PW-1:0]   den;
		lane_t           re;
		lane_t           im;
		root_t           sq;
		logic [DW-1:0]   d_re;
		logic [DW-1:0]   d_im;
		logic            d_ovf;
	} iter_t;

endpackage

// File: rtl/cau_front.sv
module cau_front import cau_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      in_op,
	input  logic signed [DW-1:0] in_a_re,
	input  logic signed [DW-1:0] in_a_im,
	input  logic signed [DW-1:0] in_b_re,
	input  logic signed [DW-1:0] in_b_im,
	output logic                 out_valid,
	input  logic                 out_ready,
	output iter_t                out_data
);

	localparam int MW = PW + FRAC_BITS;

	// Saturate a 33-bit sum to 32 bits, {ovf, value}
	function automatic logic [DW:0] sat33(input logic signed [DW:0] x);
		if (x[DW] != x[DW-1]) begin
			return {1'b1, x[DW] ? 32'h8000_0000 : 32'h7fff_ffff};
		end
		return {1'b0, x[DW-1:0]};
	endfunction

	// Saturate a 65-bit value to 32 bits, {ovf, value}
	function automatic logic [DW:0] sat65(input logic signed [PW:0] x);
		if (!(&x[PW:DW-1]) && (|x[PW:DW-1])) begin
			return {1'b1, x[PW] ? 32'h8000_0000 : 32'h7fff_ffff};
		end
		return {1'b0, x[DW-1:0]};
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic [OP_W-1:0] op_s1, op_s2, op_s3, op_s4;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2, d_rr_s2, d_ii_s2;
	logic signed [DW:0]   as_re_s2, as_im_s2, as_re_s3, as_im_s3;
	logic signed [PW:0]   pr_s3, pi_s3, nr_s3, ni_s3;
	logic [PW-1:0]        den_s3, den_s4;
	logic                 dz_s4, neg_re_s4, neg_im_s4, d_ovf_s4;
	logic [PW-1:0]        abs_re_s4, abs_im_s4, sq_s4;
	logic [DW-1:0]        d_re_s4, d_im_s4;
	iter_t                prep_s5;

	logic                 sq_op;
	logic [PW-1:0]        abs_re, abs_im, sq_sh;
	logic [DW:0]          sat_re, sat_im;
	logic [MW-1:0]        m_re, m_im;
	iter_t                prep;

	// Each stage takes a transaction when empty or when its successor moves
	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Stage 1: capture operands, feed a twice for the magnitude ops
	assign sq_op = (in_op == OP_MAG) || (in_op == OP_MAGSQ);

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= in_op;
			ar_s1 <= in_a_re;
			ai_s1 <= in_a_im;
			br_s1 <= sq_op ? in_a_re : in_b_re;
			bi_s1 <= sq_op ? in_a_im : in_b_im;
		end
	end

	// Stage 2: partial products, add and subtract
	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2    <= op_s1;
			p_rr_s2  <= ar_s1 * br_s1;
			p_ii_s2  <= ai_s1 * bi_s1;
			p_ir_s2  <= ai_s1 * br_s1;
			p_ri_s2  <= ar_s1 * bi_s1;
			d_rr_s2  <= br_s1 * br_s1;
			d_ii_s2  <= bi_s1 * bi_s1;
			as_re_s2 <= (op_s1 == OP_SUB) ? 33'(ar_s1) - 33'(br_s1) : 33'(ar_s1) + 33'(br_s1);
			as_im_s2 <= (op_s1 == OP_SUB) ? 33'(ai_s1) - 33'(bi_s1) : 33'(ai_s1) + 33'(bi_s1);
		end
	end

	// Stage 3: product sums, squared magnitude of b
	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3    <= op_s2;
			pr_s3    <= 65'(p_rr_s2) - 65'(p_ii_s2);
			pi_s3    <= 65'(p_ir_s2) + 65'(p_ri_s2);
			nr_s3    <= 65'(p_rr_s2) + 65'(p_ii_s2);
			ni_s3    <= 65'(p_ir_s2) - 65'(p_ri_s2);
			den_s3   <= 64'(d_rr_s2) + 64'(d_ii_s2);
			as_re_s3 <= as_re_s2;
			as_im_s3 <= as_im_s2;
		end
	end

	// Stage 4: finish the ops without a divider, split sign from magnitude
	assign abs_re = nr_s3[PW] ? 64'(-nr_s3) : nr_s3[PW-1:0];
	assign abs_im = ni_s3[PW] ? 64'(-ni_s3) : ni_s3[PW-1:0];
	assign sq_sh  = nr_s3[PW-1:0] >> FRAC_BITS;

	always_comb begin
		sat_re = '0;
		sat_im = '0;
		case (op_s3)
			OP_ADD, OP_SUB: begin
				sat_re = sat33(as_re_s3);
				sat_im = sat33(as_im_s3);
			end
			OP_MUL: begin
				sat_re = sat65(pr_s3 >>> FRAC_BITS);
				sat_im = sat65(pi_s3 >>> FRAC_BITS);
			end
			OP_MAGSQ: begin
				sat_re = (|sq_sh[PW-1:DW-1]) ? {1'b1, 32'h7fff_ffff} : {1'b0, sq_sh[DW-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			op_s4     <= op_s3;
			den_s4    <= den_s3;
			dz_s4     <= (den_s3 == '0);
			abs_re_s4 <= abs_re;
			abs_im_s4 <= abs_im;
			neg_re_s4 <= nr_s3[PW];
			neg_im_s4 <= ni_s3[PW];
			sq_s4     <= nr_s3[PW-1:0];
			d_re_s4   <= sat_re[DW-1:0];
			d_im_s4   <= sat_im[DW-1:0];
			d_ovf_s4  <= sat_re[DW] | sat_im[DW];
		end
	end

	// Stage 5: scale the dividends, flag quotients wider than 32 bits
	assign m_re = MW'(abs_re_s4) << FRAC_BITS;
	assign m_im = MW'(abs_im_s4) << FRAC_BITS;

	always_comb begin
		prep.op      = op_s4;
		prep.dz      = dz_s4;
		prep.den     = den_s4;
		prep.re.rem  = 64'(m_re[MW-1:DW]);
		prep.re.lq   = m_re[DW-1:0];
		prep.re.neg  = neg_re_s4;
		prep.re.povf = (64'(m_re[MW-1:DW]) >= den_s4);
		prep.im.rem  = 64'(m_im[MW-1:DW]);
		prep.im.lq   = m_im[DW-1:0];
		prep.im.neg  = neg_im_s4;
		prep.im.povf = (64'(m_im[MW-1:DW]) >= den_s4);
		prep.sq.v    = sq_s4;
		prep.sq.rem  = '0;
		prep.sq.root = '0;
		prep.d_re    = d_re_s4;
		prep.d_im    = d_im_s4;
		prep.d_ovf   = d_ovf_s4;
	end

	always_ff @(posedge clk) begin
		if (en5) prep_s5 <= prep;
	end

	assign out_valid = v_s5;
	assign out_data  = prep_s5;

endmodule

// File: rtl/cau_iter.sv
module cau_iter import cau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  iter_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output iter_t out_data
);

	// One restoring division step: bring down a bit, subtract when it fits
	function automatic lane_t lane_step(input lane_t l, input logic [PW-1:0] den);
		lane_t         r;
		logic [PW:0]   t;
		logic [PW+1:0] d;
		t      = {l.rem, l.lq[DW-1]};
		d      = {1'b0, t} - {2'b00, den};
		r      = l;
		r.rem  = d[PW+1] ? t[PW-1:0] : d[PW-1:0];
		r.lq   = {l.lq[DW-2:0], ~d[PW+1]};
		return r;
	endfunction

	// One square root digit: bring down two bits, try 4*root + 1
	function automatic root_t root_step(input root_t s);
		root_t         y;
		logic [DW+3:0] r;
		logic [DW+4:0] d;
		r      = {s.rem, s.v[PW-1:PW-2]};
		d      = {1'b0, r} - {3'b000, s.root, 2'b01};
		y.v    = {s.v[PW-3:0], 2'b00};
		y.rem  = d[DW+4] ? r[DW+1:0] : d[DW+1:0];
		y.root = {s.root[DW-2:0], ~d[DW+4]};
		return y;
	endfunction

	function automatic iter_t iter_step(input iter_t x);
		iter_t y;
		y    = x;
		y.re = lane_step(x.re, x.den);
		y.im = lane_step(x.im, x.den);
		y.sq = root_step(x.sq);
		return y;
	endfunction

	iter_t pipe_s [STEPS];
	logic  v_s    [STEPS];
	logic  en     [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		iter_t src;
		logic  src_v;
		logic  down_en;

		if (k == 0) begin : g_head
			assign src   = in_data;
			assign src_v = in_valid;
		end else begin : g_body
			assign src   = pipe_s[k-1];
			assign src_v = v_s[k-1];
		end

		if (k == STEPS-1) begin : g_tail
			assign down_en = out_ready;
		end else begin : g_link
			assign down_en = en[k+1];
		end

		// Advance when empty or when the next stage moves
		assign en[k] = !v_s[k] || down_en;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) pipe_s[k] <= iter_step(src);
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[STEPS-1];
	assign out_data  = pipe_s[STEPS-1];

endmodule

// File: rtl/cau_back.sv
module cau_back import cau_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  iter_t         in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] out_re,
	output logic [DW-1:0] out_im,
	output logic          out_ovf,
	output logic          out_dz
);

	// Apply the sign with rounding toward minus infinity, saturate; {ovf, value}
	function automatic logic [DW:0] div_fix(input lane_t l);
		logic [DW:0] c;
		c = {1'b0, l.lq} + 33'(l.rem != '0);
		if (!l.neg) begin
			if (l.povf || l.lq[DW-1]) return {1'b1, 32'h7fff_ffff};
			return {1'b0, l.lq};
		end
		if (l.povf || (c > 33'h0_8000_0000)) return {1'b1, 32'h8000_0000};
		return {1'b0, 32'(-c)};
	endfunction

	logic [DW:0]   q_re, q_im;
	logic [DW-1:0] re_d, im_d;
	logic          ovf_d, dz_d;

	logic          v_s38;
	logic [DW-1:0] res_re_s38, res_im_s38;
	logic          ovf_s38, dz_s38;

	// Pick the result by opcode
	always_comb begin
		q_re  = div_fix(in_data.re);
		q_im  = div_fix(in_data.im);
		re_d  = '0;
		im_d  = '0;
		ovf_d = 1'b0;
		dz_d  = 1'b0;
		case (in_data.op)
			OP_DIV: begin
				if (in_data.dz) begin
					dz_d = 1'b1;
				end else begin
					re_d  = q_re[DW-1:0];
					im_d  = q_im[DW-1:0];
					ovf_d = q_re[DW] | q_im[DW];
				end
			end
			OP_MAG: begin
				re_d  = in_data.sq.root[DW-1] ? 32'h7fff_ffff : in_data.sq.root;
				ovf_d = in_data.sq.root[DW-1];
			end
			default: begin
				re_d  = in_data.d_re;
				im_d  = in_data.d_im;
				ovf_d = in_data.d_ovf;
			end
		endcase
	end

	assign in_ready = !v_s38 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s38 <= 1'b0;
		end else if (in_ready) begin
			v_s38 <= in_valid;
		end
	end

	// Output register, held while the sink stalls
	always_ff @(posedge clk) begin
		if (in_ready) begin
			res_re_s38 <= re_d;
			res_im_s38 <= im_d;
			ovf_s38    <= ovf_d;
			dz_s38     <= dz_d;
		end
	end

	assign out_valid = v_s38;
	assign out_re    = res_re_s38;
	assign out_im    = res_im_s38;
	assign out_ovf   = ovf_s38;
	assign out_dz    = dz_s38;

endmodule

// File: rtl/complex_arithmetic_unit.sv
// Channel  | Signals             | Contents, lowest bit first
// ---------+---------------------+---------------------------------------------
// input    | s_axis_t*           | tdata: a_re, a_im, b_re, b_im; tuser: op
// output   | m_axis_t*           | tdata: res_re, res_im; tuser: overflow, div_zero
//
// One transaction per cycle while the output is not stalled; five front stages (capture,
// products, sums, saturation, dividend scaling), 32 iteration stages that each
// retire one quotient bit per divider lane and one root bit, one output register.
// Reset clears every valid bit at once; no clearing pass is needed.
// A stage takes a new transaction when it is empty or its successor moves, so a
// stalled output holds its result and bubbles upstream still close up.
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [4*DW-1:0]   s_axis_tdata,  // a_re, a_im, b_re, b_im
	input  logic [OP_W-1:0]   s_axis_tuser,  // op
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [2*DW-1:0]   m_axis_tdata,  // res_re, res_im
	output logic [1:0]        m_axis_tuser   // overflow, div_zero
);

	logic  fr_valid, fr_ready;
	iter_t fr_data;
	logic  it_valid, it_ready;
	iter_t it_data;
	logic [DW-1:0] res_re, res_im;
	logic          ovf, dz;

	cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_a_re   (s_axis_tdata[DW-1:0]),
		.in_a_im   (s_axis_tdata[2*DW-1:DW]),
		.in_b_re   (s_axis_tdata[3*DW-1:2*DW]),
		.in_b_im   (s_axis_tdata[4*DW-1:3*DW]),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_data  (fr_data)
	);

	cau_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   (fr_data),
		.out_valid (it_valid),
		.out_ready (it_ready),
		.out_data  (it_data)
	);

	cau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (it_valid),
		.in_ready  (it_ready),
		.in_data   (it_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_re    (res_re),
		.out_im    (res_im),
		.out_ovf   (ovf),
		.out_dz    (dz)
	);

	assign m_axis_tdata = {res_im, res_re};
	assign m_axis_tuser = {dz, ovf};

endmodule

// File: rtl/cau_checker.sv
module cau_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [127:0] s_axis_tdata,
	input logic [2:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [63:0]  m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);

	// Hold a waiting input transaction unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
		else $error("waiting input transaction changed");

	// Hold a stalled result unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// Divide by zero gives zero and no saturation
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == 64'd0) && !m_axis_tuser[0])
		else $error("divide by zero result not clean");

	// Saturation leaves a part at a range limit
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			(m_axis_tdata[31:0] == 32'h7fff_ffff) || (m_axis_tdata[31:0] == 32'h8000_0000) ||
			(m_axis_tdata[63:32] == 32'h7fff_ffff) || (m_axis_tdata[63:32] == 32'h8000_0000))
		else $error("overflow flagged without saturated part");

	// Drop output valid while in reset
	a_rst: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// File: bench/cau_result_checker.sv
`timescale 1ns / 100ps

module cau_result_checker import cau_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            s_axis_tvalid,
	input  logic            s_axis_tready,
	input  logic [4*DW-1:0] s_axis_tdata,
	input  logic [OP_W-1:0] s_axis_tuser,
	input  logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	input  logic [2*DW-1:0] m_axis_tdata,
	input  logic [1:0]      m_axis_tuser,
	output int              fail_count,
	output int              pending,
	output int              result_count
);

	typedef struct packed {
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic          ovf;
		logic          dz;
	} cplx_result_t;

	localparam logic signed [127:0] POS_LIMIT = 128'sd2147483647;
	localparam logic signed [127:0] NEG_LIMIT = -128'sd2147483648;

	cplx_result_t expected_results[$];

	// Clamp a wide value to 32 bits, flag any saturation
	function automatic logic [DW-1:0] clamp32(input logic signed [127:0] v, inout logic ovf);
		if (v > POS_LIMIT) begin
			ovf = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < NEG_LIMIT) begin
			ovf = 1'b1;
			return 32'h8000_0000;
		end
		return v[DW-1:0];
	endfunction

	// Floor of the exact square root
	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] one;
		res = '0;
		one = 64'd1 << 62;
		while (one > v) one = one >> 2;
		while (one != 0) begin
			if (v >= res + one) begin
				v   = v - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	// Quotient rounded toward minus infinity, den > 0
	function automatic logic signed [127:0] floor_div(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic signed [127:0] q;
		q = num / den;
		if (num < 0 && (num % den) != 0) q = q - 1;
		return q;
	endfunction

	function automatic cplx_result_t predict_complex(input logic [OP_W-1:0] op,
			input logic [DW-1:0] ar, input logic [DW-1:0] ai,
			input logic [DW-1:0] br, input logic [DW-1:0] bi);
		cplx_result_t r;
		logic signed [127:0] xr, xi, yr, yi, den, nr, ni;
		logic [63:0] s;
		logic ovf;
		xr = $signed(ar);
		xi = $signed(ai);
		yr = $signed(br);
		yi = $signed(bi);
		ovf = 1'b0;
		r = '0;
		case (op)
			OP_ADD: begin
				r.re = clamp32(xr + yr, ovf);
				r.im = clamp32(xi + yi, ovf);
			end
			OP_SUB: begin
				r.re = clamp32(xr - yr, ovf);
				r.im = clamp32(xi - yi, ovf);
			end
			OP_MUL: begin
				r.re = clamp32((xr * yr - xi * yi) >>> FRAC_BITS, ovf);
				r.im = clamp32((xi * yr + xr * yi) >>> FRAC_BITS, ovf);
			end
			OP_DIV: begin
				den = yr * yr + yi * yi;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					nr = (xr * yr + xi * yi) <<< FRAC_BITS;
					ni = (xi * yr - xr * yi) <<< FRAC_BITS;
					r.re = clamp32(floor_div(nr, den), ovf);
					r.im = clamp32(floor_div(ni, den), ovf);
				end
			end
			OP_MAG, OP_MAGSQ: begin
				s = 64'(xr * xr + xi * xi);
				if (op == OP_MAG) r.re = clamp32({64'd0, root64(s)}, ovf);
				else r.re = clamp32({64'd0, s >> FRAC_BITS}, ovf);
			end
			default: r = '0;
		endcase
		r.ovf = ovf;
		return r;
	endfunction

	initial begin
		fail_count   = 0;
		pending      = 0;
		result_count = 0;
	end

	// Predict on input transactions, compare on output transactions
	always @(posedge clk) begin
		cplx_result_t want, got;
		if (s_axis_tvalid && s_axis_tready) begin
			expected_results.push_back(predict_complex(s_axis_tuser,
				s_axis_tdata[DW-1:0], s_axis_tdata[2*DW-1:DW],
				s_axis_tdata[3*DW-1:2*DW], s_axis_tdata[4*DW-1:3*DW]));
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[DW-1:0], m_axis_tdata[2*DW-1:DW],
				m_axis_tuser[0], m_axis_tuser[1]};
			result_count <= result_count + 1;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result re=%h im=%h ovf=%b dz=%b",
					$time, got.re, got.im, got.ovf, got.dz);
				fail_count <= fail_count + 1;
			end else begin
				want = expected_results.pop_front();
				if (want !== got) begin
					$display("%0t: expected re=%h im=%h ovf=%b dz=%b, got re=%h im=%h ovf=%b dz=%b",
						$time, want.re, want.im, want.ovf, want.dz,
						got.re, got.im, got.ovf, got.dz);
					fail_count <= fail_count + 1;
				end
			end
		end
		pending <= expected_results.size();
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb import cau_pkg::*;;

	localparam int STALL_LIMIT = 4000;

	logic            clk;
	logic            arst_n;
	logic            s_axis_tvalid;
	logic            s_axis_tready;
	logic [4*DW-1:0] s_axis_tdata;   // a_re, a_im, b_re, b_im
	logic [OP_W-1:0] s_axis_tuser;   // op
	logic            m_axis_tvalid;
	logic            m_axis_tready;
	logic [2*DW-1:0] m_axis_tdata;   // res_re, res_im
	logic [1:0]      m_axis_tuser;   // overflow, div_zero

	int fail_count, pending, result_count;
	int send_idle_pct, recv_stall_pct;
	int quiet_cycles;
	int items_sent;

	complex_arithmetic_unit #(.FRAC_BITS(16)) uut (.*);

	cau_result_checker #(.FRAC_BITS(16)) u_checker (
		.clk, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
		.fail_count, .pending, .result_count
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Randomize output backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("complex_arithmetic_unit: mismatch");
			$finish;
		end
	end

	// Offer one operation and hold it until accepted
	task automatic send_op(input logic [OP_W-1:0] op, input logic [DW-1:0] ar,
			input logic [DW-1:0] ai, input logic [DW-1:0] br, input logic [DW-1:0] bi);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {bi, br, ai, ar};
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end while (!taken);
		items_sent++;
	endtask

	// Operand mix: full range, small magnitudes, extremes, zero
	function automatic logic [DW-1:0] pick_operand();
		case ($urandom_range(9))
			0, 1, 2: return $urandom;
			3, 4, 5: return DW'($signed($urandom_range(20 << 16)) - (10 << 16));
			6:       return DW'($signed($urandom_range(1024)) - 512);
			7: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0001_0000;
				endcase
			end
			default: return '0;
		endcase
	endfunction

	task automatic run_random(input int count);
		logic [OP_W-1:0] op;
		logic [DW-1:0] br, bi;
		repeat (count) begin
			op = OP_W'($urandom_range(OP_MAGSQ));
			br = pick_operand();
			bi = pick_operand();
			if (op == OP_DIV && $urandom_range(15) == 0) begin
				br = '0;
				bi = '0;
			end
			send_op(op, pick_operand(), pick_operand(), br, bi);
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		m_axis_tready  = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		quiet_cycles   = 0;
		items_sent     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: each operation, extremes, saturation, divide by zero
		send_op(OP_ADD,   32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
		send_op(OP_ADD,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		send_op(OP_SUB,   32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		send_op(OP_SUB,   32'h0005_8000, 32'h0000_0000, 32'h0002_4000, 32'h0001_0000);
		send_op(OP_MUL,   32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFB_0000);
		send_op(OP_MUL,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_op(OP_MUL,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
		send_op(OP_MUL,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_op(OP_DIV,   32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(OP_DIV,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(OP_DIV,   32'h0001_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
		send_op(OP_DIV,   32'hFFFF_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
		send_op(OP_DIV,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
		send_op(OP_DIV,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_op(OP_DIV,   32'h0005_0000, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000);
		send_op(OP_MAG,   32'h0003_0000, 32'h0004_0000, 32'h1234_5678, 32'h9ABC_DEF0);
		send_op(OP_MAG,   32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(OP_MAG,   32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(OP_MAG,   32'h0000_0002, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(OP_MAGSQ, 32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(OP_MAGSQ, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_op(OP_MAGSQ, 32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0000, 32'h0000_0000);

		// Random phases with varying idle and backpressure
		run_random(420);
		send_idle_pct = 45;
		run_random(420);
		send_idle_pct  = 0;
		recv_stall_pct = 45;
		run_random(420);
		send_idle_pct  = 8;
		recv_stall_pct = 8;
		run_random(420);

		// Drain the pipeline
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("Sent %0d operations across all six opcodes, %0d results checked,",
			items_sent, result_count);
		$display("under four idle and backpressure mixes with edge and random operands.");
		if (fail_count == 0) begin
			$display("complex_arithmetic_unit: match");
		end else begin
			$display("complex_arithmetic_unit: mismatch");
		end
		$finish;
	end

endmodule

// File: complex_arithmetic_unit.f
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_iter.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
bench/cau_result_checker.sv
bench/tb.sv
